// ----- rtl/assert_macros.svh -----
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on the rising clock, off during reset
`define DUST_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// next-cycle implication, sampled on the rising clock, off during reset
`define DUST_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ----- rtl/dust_pkg.sv -----
// shared types and constants of the daily usage stats table
`default_nettype none

package dust_pkg;

  localparam int unsigned DAY_W   = 16;
  localparam int unsigned SUM_W   = 32;
  localparam int unsigned CNT16_W = 16;
  localparam int unsigned LIMIT_W = 4;

  localparam logic [CNT16_W-1:0] SAT16       = 16'hFFFF;
  localparam logic [LIMIT_W-1:0] MAX_RESULTS = 4'd14;

  localparam logic OP_RECORD = 1'b0;
  localparam logic OP_LIST   = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WRITE,
    ST_PICK,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic [DAY_W-1:0]   day;
    logic [CNT16_W-1:0] secs;
    logic [CNT16_W-1:0] pages;
  } slot_t;

  typedef struct packed {
    logic [SUM_W-1:0]   sum_seconds;
    logic [SUM_W-1:0]   sum_pages;
    logic [CNT16_W-1:0] session_count;
    logic [DAY_W-1:0]   bucket_day;
    logic [CNT16_W-1:0] bucket_seconds;
    logic [CNT16_W-1:0] bucket_pages;
    logic               bucket_valid;
    logic               last_item;
  } result_t;

endpackage

`default_nettype wire

// ----- rtl/dust_in_if.sv -----
// request channel: valid/ready handshake with the session or list payload
`default_nettype none

interface dust_in_if;
  import dust_pkg::*;

  logic               valid;
  logic               ready;
  logic               opcode;
  logic [DAY_W-1:0]   day_number;
  logic [SUM_W-1:0]   session_seconds;
  logic [SUM_W-1:0]   session_pages;
  logic [LIMIT_W-1:0] max_days;

  modport source (
    output valid, opcode, day_number, session_seconds, session_pages, max_days,
    input  ready
  );

  modport sink (
    input  valid, opcode, day_number, session_seconds, session_pages, max_days,
    output ready
  );
endinterface

`default_nettype wire

// ----- rtl/dust_out_if.sv -----
// result channel: valid/ready handshake with totals and one day bucket
`default_nettype none

interface dust_out_if;
  import dust_pkg::*;

  logic               valid;
  logic               ready;
  logic [SUM_W-1:0]   sum_seconds;
  logic [SUM_W-1:0]   sum_pages;
  logic [CNT16_W-1:0] session_count;
  logic [DAY_W-1:0]   bucket_day;
  logic [CNT16_W-1:0] bucket_seconds;
  logic [CNT16_W-1:0] bucket_pages;
  logic               bucket_valid;
  logic               last_item;

  modport source (
    output valid, sum_seconds, sum_pages, session_count, bucket_day, bucket_seconds,
    output bucket_pages, bucket_valid, last_item,
    input  ready
  );

  modport sink (
    input  valid, sum_seconds, sum_pages, session_count, bucket_day, bucket_seconds,
    input  bucket_pages, bucket_valid, last_item,
    output ready
  );
endinterface

`default_nettype wire

// ----- rtl/daily_usage_stats_table_top.sv -----
// daily usage stats table: running totals plus a scanned table of per-day buckets
// A record request adds a session into the wrapping 32-bit totals and the
// saturating session count, then finds or replaces the bucket of its day and
// returns exactly one result with the totals and that bucket. A list request
// returns up to max_days (at most 14) of the first non-empty buckets in table
// order, sorted by day, most recent first, one result per bucket, last_item
// marking the final one; it returns nothing when no bucket qualifies. The
// bucket table is a memory with one write port and one registered read port,
// so every request walks it one entry per cycle. A record request walks the
// table once. A list request walks it once per result (selection by day), and
// once when it yields none. The block handles one request at a time and holds
// ready low until it is done. Memory contents need no clearing after reset: a
// valid bit per bucket, cleared by reset, makes an unwritten bucket read as
// empty.
`default_nettype none

module daily_usage_stats_table_top #(
  parameter int unsigned DAY_SLOTS = 14
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  dust_in_if.sink    in_i,
  dust_out_if.source out_o
);
  import dust_pkg::*;

  localparam int unsigned IDX_W = (DAY_SLOTS > 1) ? $clog2(DAY_SLOTS) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DAY_SLOTS - 1);

  // sequencer
  state_e state_q, state_d;

  // latched request
  logic               op_q;
  logic [DAY_W-1:0]   day_q;
  logic [SUM_W-1:0]   sec_q;
  logic [SUM_W-1:0]   pg_q;
  logic [LIMIT_W-1:0] limit_q;

  // running totals
  logic [SUM_W-1:0]   acc_sec_q;
  logic [SUM_W-1:0]   acc_pg_q;
  logic [CNT16_W-1:0] acc_sess_q;

  // bucket table: memory plus a valid bit per entry
  slot_t                slot_mem [DAY_SLOTS];
  slot_t                rd_q;
  logic [DAY_SLOTS-1:0] slot_vld_q;

  // table walk: read address stage and compare stage
  logic             rd_en_q;
  logic [IDX_W-1:0] rd_idx_q;
  logic             cmp_vld_q;
  logic [IDX_W-1:0] cmp_idx_q;

  // record search results
  logic               match_found_q;
  logic [IDX_W-1:0]   match_idx_q;
  logic [CNT16_W-1:0] match_sec_q;
  logic [CNT16_W-1:0] match_pg_q;
  logic [DAY_W-1:0]   low_day_q;
  logic [IDX_W-1:0]   low_idx_q;

  // list selection
  logic [LIMIT_W-1:0] cnt_q;
  logic               best_found_q;
  logic [DAY_W-1:0]   best_day_q;
  logic [IDX_W-1:0]   best_idx_q;
  logic [CNT16_W-1:0] best_sec_q;
  logic [CNT16_W-1:0] best_pg_q;
  logic               have_prev_q;
  logic [DAY_W-1:0]   prev_day_q;
  logic [IDX_W-1:0]   prev_idx_q;
  logic [LIMIT_W-1:0] emit_cnt_q;

  // result register
  result_t out_q;

  // control decode
  logic in_ready;
  logic out_valid;
  logic accept;
  logic scan_start;
  logic load_rec;
  logic load_list;
  logic out_take;

  // compare stage
  logic [DAY_W-1:0] eff_day;
  logic             is_match;
  logic             is_low;
  logic             eligible;
  logic             after_prev;
  logic             take_best;

  // record update path
  logic               nz;
  logic [IDX_W-1:0]   wr_idx;
  logic [CNT16_W-1:0] base_sec;
  logic [CNT16_W-1:0] base_pg;
  logic [SUM_W:0]     sum_sec;
  logic [SUM_W:0]     sum_pg;
  logic [CNT16_W-1:0] new_sec;
  logic [CNT16_W-1:0] new_pg;
  logic [CNT16_W-1:0] new_sess;
  logic               wr_en;
  slot_t              wr_slot;
  logic               rec_has;
  logic [LIMIT_W-1:0] limit_in;
  logic               list_last;

  // ---------------------------------------------------------------------------
  // next state
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_i.valid) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        // walk ends once the last entry has been compared
        if (cmp_vld_q && (cmp_idx_q == LAST_IDX)) begin
          state_d = (op_q == OP_LIST) ? ST_PICK : ST_WRITE;
        end
      end
      ST_WRITE: begin
        state_d = ST_OUT;
      end
      ST_PICK: begin
        state_d = best_found_q ? ST_OUT : ST_IDLE;
      end
      ST_OUT: begin
        if (out_o.ready) begin
          // list requests walk the table again for the next bucket
          state_d = out_q.last_item ? ST_IDLE : ST_SCAN;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // control outputs
  // ---------------------------------------------------------------------------
  always_comb begin
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    scan_start = 1'b0;
    load_rec   = 1'b0;
    load_list  = 1'b0;
    out_take   = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready   = 1'b1;
        scan_start = in_i.valid;
      end
      ST_WRITE: begin
        load_rec = 1'b1;
      end
      ST_PICK: begin
        load_list = best_found_q;
      end
      ST_OUT: begin
        out_valid  = 1'b1;
        out_take   = out_o.ready;
        scan_start = out_o.ready && !out_q.last_item;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  assign accept      = in_i.valid && in_ready;
  assign in_i.ready  = in_ready;
  assign out_o.valid = out_valid;

  // clip the list limit to the most results per request
  assign limit_in = (in_i.max_days > MAX_RESULTS) ? MAX_RESULTS : in_i.max_days;

  // ---------------------------------------------------------------------------
  // compare stage of the table walk
  // ---------------------------------------------------------------------------
  // a bucket never written since reset reads as empty
  assign eff_day  = slot_vld_q[cmp_idx_q] ? rd_q.day : '0;

  // first bucket holding the request's day
  assign is_match = cmp_vld_q && (day_q != '0) && (eff_day == day_q) && !match_found_q;

  // first bucket with the lowest day, empty buckets rank lowest
  assign is_low   = cmp_vld_q && ((cmp_idx_q == '0) || (eff_day < low_day_q));

  // only the first limit non-empty buckets in table order take part in a list
  assign eligible = cmp_vld_q && (eff_day != '0) && (cnt_q < limit_q);

  // order is day descending then index ascending; skip what was already sent
  assign after_prev = !have_prev_q || (eff_day < prev_day_q) ||
                      ((eff_day == prev_day_q) && (cmp_idx_q > prev_idx_q));

  assign take_best = eligible && after_prev && (!best_found_q || (eff_day > best_day_q));

  // ---------------------------------------------------------------------------
  // record update: one saturating add per field
  // ---------------------------------------------------------------------------
  assign nz       = (sec_q != '0) || (pg_q != '0);
  assign wr_idx   = match_found_q ? match_idx_q : low_idx_q;
  assign base_sec = match_found_q ? match_sec_q : '0;
  assign base_pg  = match_found_q ? match_pg_q  : '0;

  assign sum_sec = {{(SUM_W - CNT16_W + 1){1'b0}}, base_sec} + {1'b0, sec_q};
  assign sum_pg  = {{(SUM_W - CNT16_W + 1){1'b0}}, base_pg}  + {1'b0, pg_q};
  assign new_sec = (sum_sec > {{(SUM_W - CNT16_W + 1){1'b0}}, SAT16}) ? SAT16 : sum_sec[CNT16_W-1:0];
  assign new_pg  = (sum_pg  > {{(SUM_W - CNT16_W + 1){1'b0}}, SAT16}) ? SAT16 : sum_pg[CNT16_W-1:0];

  assign new_sess = (nz && (acc_sess_q != SAT16)) ? (acc_sess_q + 16'd1) : acc_sess_q;

  assign wr_en   = (state_q == ST_WRITE) && nz && (day_q != '0);
  assign wr_slot = '{day: day_q, secs: new_sec, pages: new_pg};

  // the day's bucket exists after this request if it was found or just made
  assign rec_has = (day_q != '0) && (nz || match_found_q);

  assign list_last = (LIMIT_W'(emit_cnt_q + 4'd1) == cnt_q);

  // ---------------------------------------------------------------------------
  // control registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      acc_sec_q     <= '0;
      acc_pg_q      <= '0;
      acc_sess_q    <= '0;
      slot_vld_q    <= '0;
      rd_en_q       <= 1'b0;
      rd_idx_q      <= '0;
      cmp_vld_q     <= 1'b0;
      cmp_idx_q     <= '0;
      match_found_q <= 1'b0;
      cnt_q         <= '0;
      best_found_q  <= 1'b0;
      have_prev_q   <= 1'b0;
      emit_cnt_q    <= '0;
    end else begin
      state_q   <= state_d;
      cmp_vld_q <= rd_en_q;
      cmp_idx_q <= rd_idx_q;

      // read address stage
      if (scan_start) begin
        rd_en_q  <= 1'b1;
        rd_idx_q <= '0;
      end else if (rd_en_q) begin
        if (rd_idx_q == LAST_IDX) begin
          rd_en_q <= 1'b0;
        end else begin
          rd_idx_q <= rd_idx_q + IDX_W'(1);
        end
      end

      // per-walk search flags
      if (scan_start) begin
        match_found_q <= 1'b0;
        cnt_q         <= '0;
        best_found_q  <= 1'b0;
      end else begin
        if (is_match) begin
          match_found_q <= 1'b1;
        end
        if (eligible) begin
          cnt_q <= cnt_q + LIMIT_W'(1);
        end
        if (take_best) begin
          best_found_q <= 1'b1;
        end
      end

      if (accept) begin
        have_prev_q <= 1'b0;
        emit_cnt_q  <= '0;
      end else begin
        if (load_list) begin
          have_prev_q <= 1'b1;
        end
        if (out_take) begin
          emit_cnt_q <= emit_cnt_q + LIMIT_W'(1);
        end
      end

      // totals and bucket valid bits
      if (load_rec) begin
        acc_sec_q  <= acc_sec_q + sec_q;
        acc_pg_q   <= acc_pg_q + pg_q;
        acc_sess_q <= new_sess;
      end
      if (wr_en) begin
        slot_vld_q[wr_idx] <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // payload registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q    <= in_i.opcode;
      day_q   <= in_i.day_number;
      sec_q   <= in_i.session_seconds;
      pg_q    <= in_i.session_pages;
      limit_q <= limit_in;
    end

    if (is_match) begin
      match_idx_q <= cmp_idx_q;
      match_sec_q <= rd_q.secs;
      match_pg_q  <= rd_q.pages;
    end
    if (is_low) begin
      low_day_q <= eff_day;
      low_idx_q <= cmp_idx_q;
    end
    if (take_best) begin
      best_day_q <= eff_day;
      best_idx_q <= cmp_idx_q;
      best_sec_q <= rd_q.secs;
      best_pg_q  <= rd_q.pages;
    end
    if (load_list) begin
      prev_day_q <= best_day_q;
      prev_idx_q <= best_idx_q;
    end

    if (load_rec) begin
      out_q.sum_seconds    <= acc_sec_q + sec_q;
      out_q.sum_pages      <= acc_pg_q + pg_q;
      out_q.session_count  <= new_sess;
      out_q.bucket_day     <= rec_has ? day_q : '0;
      out_q.bucket_seconds <= rec_has ? new_sec : '0;
      out_q.bucket_pages   <= rec_has ? new_pg : '0;
      out_q.bucket_valid   <= rec_has;
      out_q.last_item      <= 1'b1;
    end else if (load_list) begin
      out_q.sum_seconds    <= acc_sec_q;
      out_q.sum_pages      <= acc_pg_q;
      out_q.session_count  <= acc_sess_q;
      out_q.bucket_day     <= best_day_q;
      out_q.bucket_seconds <= best_sec_q;
      out_q.bucket_pages   <= best_pg_q;
      out_q.bucket_valid   <= 1'b1;
      out_q.last_item      <= list_last;
    end
  end

  // ---------------------------------------------------------------------------
  // bucket memory: one write port, one registered read port
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      slot_mem[wr_idx] <= wr_slot;
    end
    rd_q <= slot_mem[rd_idx_q];
  end

  // result port
  assign out_o.sum_seconds    = out_q.sum_seconds;
  assign out_o.sum_pages      = out_q.sum_pages;
  assign out_o.session_count  = out_q.session_count;
  assign out_o.bucket_day     = out_q.bucket_day;
  assign out_o.bucket_seconds = out_q.bucket_seconds;
  assign out_o.bucket_pages   = out_q.bucket_pages;
  assign out_o.bucket_valid   = out_q.bucket_valid;
  assign out_o.last_item      = out_q.last_item;

endmodule

`default_nettype wire

// ----- rtl/dust_checker.sv -----
// port-level checks of the daily usage stats table and their bind
`default_nettype none

`include "assert_macros.svh"

module dust_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_ready_i,
  input logic                         out_valid_i,
  input logic                         out_ready_i,
  input logic [dust_pkg::DAY_W-1:0]   bucket_day_i,
  input logic [dust_pkg::CNT16_W-1:0] bucket_seconds_i,
  input logic [dust_pkg::CNT16_W-1:0] bucket_pages_i,
  input logic                         bucket_valid_i,
  input logic                         last_item_i
);
  import dust_pkg::*;

  // a stalled result stays offered, with its bucket day and last_item unchanged
  `DUST_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i && $stable(bucket_day_i) && $stable(last_item_i))

  // one request at a time: no new request while a result is pending
  `DUST_ASSERT_IMPL(a_busy_out, clk_i, rst_ni, out_valid_i, !in_ready_i)

  // the table walk follows every accepted request
  `DUST_ASSERT_NEXT(a_busy_after_req, clk_i, rst_ni, in_valid_i && in_ready_i, !in_ready_i)

  // a result without a bucket only ends a record request and carries zeros
  `DUST_ASSERT_IMPL(a_empty_bucket, clk_i, rst_ni, out_valid_i && !bucket_valid_i, last_item_i && (bucket_day_i == '0) && (bucket_seconds_i == '0) && (bucket_pages_i == '0))

  // a real bucket never carries the empty day
  `DUST_ASSERT_IMPL(a_real_bucket, clk_i, rst_ni, out_valid_i && bucket_valid_i, bucket_day_i != '0)

endmodule

bind daily_usage_stats_table_top dust_checker u_dust_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_i.valid),
  .in_ready_i       (in_i.ready),
  .out_valid_i      (out_o.valid),
  .out_ready_i      (out_o.ready),
  .bucket_day_i     (out_o.bucket_day),
  .bucket_seconds_i (out_o.bucket_seconds),
  .bucket_pages_i   (out_o.bucket_pages),
  .bucket_valid_i   (out_o.bucket_valid),
  .last_item_i      (out_o.last_item)
);

`default_nettype wire
